FILE: rtl/midway_histogram_equalization_unit_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the midway histogram equalization unit
// Checks are compiled in unless SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef MIDWAY_HISTOGRAM_EQUALIZATION_UNIT_DEFINES_SVH
`define MIDWAY_HISTOGRAM_EQUALIZATION_UNIT_DEFINES_SVH
`ifndef SYNTH
// plain property check on clk_i with reset disable
`define MHEQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("mheq assertion failed");
// implication check: condition implies consequence in the same cycle
`define MHEQ_ASSERT_IMP(lbl, cond, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (cons)) \
    else $error("mheq implication failed");
`else
`define MHEQ_ASSERT(lbl, prop)
`define MHEQ_ASSERT_IMP(lbl, cond, cons)
`endif
`endif

FILE: rtl/mheq_pkg.sv
// ---------------------------------------------------------------------------
// mheq_pkg
// Shared constants, op codes and controller/datapath bundles.
// ---------------------------------------------------------------------------
package mheq_pkg;

  localparam int unsigned MAX_PIXELS_DEF = 4096;
  localparam int unsigned PIXEL_BITS     = 16;
  localparam int unsigned STORE_BITS     = PIXEL_BITS + 1;
  localparam int unsigned INDEX_BITS     = 12;
  localparam int unsigned DIM_BITS       = 7;
  localparam int unsigned CFG_IDX_BITS   = 2;
  localparam logic [DIM_BITS-1:0] DIM_RESET = 7'd64;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT = 2'd1;

  typedef enum logic [2:0] {
    OP_LOAD1 = 3'd0,
    OP_LOAD2 = 3'd1,
    OP_EQUAL = 3'd2,
    OP_READ1 = 3'd3,
    OP_READ2 = 3'd4
  } op_e;

  localparam logic KIND_DONE = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // commands from controller to datapath
  typedef struct packed {
    logic accept;
    logic res_read;
    logic res_done;
    logic eq_init;
    logic rk_fetch;
    logic rk_cap;
    logic rk_sweep;
    logic rk_write;
    logic av_val;
    logic av_write;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic n_zero;
    logic i_last;
    logic j_last;
    logic r_last;
  } sts_t;

endpackage

FILE: rtl/mheq_stream_if.sv
// ---------------------------------------------------------------------------
// mheq_stream_if
// Valid/ready channels for command beats and result beats.
// ---------------------------------------------------------------------------
interface mheq_in_if;
  logic                              valid;
  logic                              ready;
  logic [2:0]                        op;
  logic [mheq_pkg::INDEX_BITS-1:0]   pixel_index;
  logic [mheq_pkg::PIXEL_BITS-1:0]   pixel_value;
  modport source (output valid, op, pixel_index, pixel_value, input ready);
  modport sink   (input valid, op, pixel_index, pixel_value, output ready);
endinterface

interface mheq_out_if;
  logic                              valid;
  logic                              ready;
  logic                              result_kind;
  logic [mheq_pkg::INDEX_BITS-1:0]   result_index;
  logic [mheq_pkg::STORE_BITS-1:0]   result_value;
  modport source (output valid, result_kind, result_index, result_value, input ready);
  modport sink   (input valid, result_kind, result_index, result_value, output ready);
endinterface

FILE: rtl/midway_histogram_equalization_unit.sv
// A load gives no result beat; a read loads the result register in ST_READ, then offers its result beat.
// Equalize runs the rank pass, which sweeps each image store once per pixel through its single
// read port, then the average pass, before its result beat.
// One command beat at a time: loads stream one per cycle, reads and equalize block.
// Reset is asynchronous, active low; width and height return to 64, stores are
// undefined until loaded.
// ---------------------------------------------------------------------------
// midway_histogram_equalization_unit
// Midway equalization of two images held in on-chip stores.
// ---------------------------------------------------------------------------
module midway_histogram_equalization_unit #(
  parameter int unsigned MAX_PIXELS = mheq_pkg::MAX_PIXELS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mheq_pkg::CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [mheq_pkg::DIM_BITS-1:0]     cfg_data_i,
  mheq_in_if.sink                           in_i,
  mheq_out_if.source                        out_o
);

  mheq_pkg::cmd_t cmd;
  mheq_pkg::sts_t sts;

  // controller
  mheq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_op_i     (in_i.op),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath
  mheq_datapath #(.MAX_PIXELS(MAX_PIXELS)) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_op_i     (in_i.op),
    .in_index_i  (in_i.pixel_index),
    .in_value_i  (in_i.pixel_value),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_kind_o  (out_o.result_kind),
    .res_index_o (out_o.result_index),
    .res_value_o (out_o.result_value)
  );

endmodule

FILE: rtl/mheq_datapath.sv
// ---------------------------------------------------------------------------
// mheq_datapath
// Image stores, rank order stores, rank counters and result register.
// ---------------------------------------------------------------------------
module mheq_datapath #(
  parameter int unsigned MAX_PIXELS = mheq_pkg::MAX_PIXELS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [mheq_pkg::CFG_IDX_BITS-1:0]      cfg_idx_i,
  input  logic [mheq_pkg::DIM_BITS-1:0]          cfg_data_i,
  input  logic [2:0]                             in_op_i,
  input  logic [mheq_pkg::INDEX_BITS-1:0]        in_index_i,
  input  logic [mheq_pkg::PIXEL_BITS-1:0]        in_value_i,
  input  mheq_pkg::cmd_t                         cmd_i,
  output mheq_pkg::sts_t                         sts_o,
  output logic                                   res_kind_o,
  output logic [mheq_pkg::INDEX_BITS-1:0]        res_index_o,
  output logic [mheq_pkg::STORE_BITS-1:0]        res_value_o
);

  localparam int unsigned AW = $clog2(MAX_PIXELS);
  localparam int unsigned CW = $clog2(MAX_PIXELS + 1);
  localparam int unsigned SW = mheq_pkg::STORE_BITS;
  localparam int unsigned DW = mheq_pkg::DIM_BITS;

  logic [SW-1:0] store1_mem [MAX_PIXELS];
  logic [SW-1:0] store2_mem [MAX_PIXELS];
  logic [AW-1:0] ord1_mem   [MAX_PIXELS];
  logic [AW-1:0] ord2_mem   [MAX_PIXELS];

  logic [DW-1:0]   width_q, height_q;
  logic [CW-1:0]   pix_cnt_q;
  logic [2*DW-1:0] prod;
  logic [31:0]     in_idx32;
  logic            in_range;
  logic [AW-1:0]   in_addr;

  logic [AW-1:0] i_cnt_q, j_cnt_q, r_cnt_q, cmp_j_q;
  logic          cmp_en_q;
  logic [AW-1:0] rank1_q, rank2_q;
  logic [SW-1:0] vi1_q, vi2_q;
  logic [AW-1:0] p_q, q_q;

  logic [SW-1:0] rd1_q, rd2_q;
  logic [AW-1:0] ord1_rd_q, ord2_rd_q;
  logic [AW-1:0] ra1, ra2, wa1, wa2;
  logic          we1, we2;
  logic [SW-1:0] wd1, wd2;
  logic [SW:0]   sum;
  logic          less1, less2;

  logic [2:0]    req_op_q;
  logic [mheq_pkg::INDEX_BITS-1:0] req_idx_q;
  logic          req_range_q;

  logic                 res_kind_q;
  logic [mheq_pkg::INDEX_BITS-1:0] res_index_q;
  logic [SW-1:0]        res_value_q;

  // configuration registers and saturated pixel count
  assign prod = {{DW{1'b0}}, width_q} * {{DW{1'b0}}, height_q};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= mheq_pkg::DIM_RESET;
      height_q  <= mheq_pkg::DIM_RESET;
      pix_cnt_q <= '0;
    end else begin
      if (cfg_we_i && cfg_idx_i == mheq_pkg::REG_WIDTH)  width_q  <= cfg_data_i;
      if (cfg_we_i && cfg_idx_i == mheq_pkg::REG_HEIGHT) height_q <= cfg_data_i;
      if (32'(prod) > 32'(MAX_PIXELS)) pix_cnt_q <= CW'(MAX_PIXELS);
      else                             pix_cnt_q <= CW'(prod);
    end
  end

  // command beat decode
  assign in_idx32 = 32'(in_index_i);
  assign in_range = in_idx32 < 32'(MAX_PIXELS);
  assign in_addr  = in_idx32[AW-1:0];

  // status flags
  assign sts_o.n_zero = (pix_cnt_q == '0);
  assign sts_o.i_last = (CW'(i_cnt_q) + CW'(1)) == pix_cnt_q;
  assign sts_o.j_last = (CW'(j_cnt_q) + CW'(1)) == pix_cnt_q;
  assign sts_o.r_last = (CW'(r_cnt_q) + CW'(1)) == pix_cnt_q;

  // store port selection
  always_comb begin
    if (cmd_i.accept) begin
      ra1 = in_addr;
      ra2 = in_addr;
    end else if (cmd_i.rk_fetch) begin
      ra1 = i_cnt_q;
      ra2 = i_cnt_q;
    end else if (cmd_i.rk_sweep) begin
      ra1 = j_cnt_q;
      ra2 = j_cnt_q;
    end else begin
      ra1 = ord1_rd_q;
      ra2 = ord2_rd_q;
    end
  end

  assign sum = {1'b0, rd1_q} + {1'b0, rd2_q};
  assign we1 = (cmd_i.accept && in_op_i == mheq_pkg::OP_LOAD1 && in_range) || cmd_i.av_write;
  assign we2 = (cmd_i.accept && in_op_i == mheq_pkg::OP_LOAD2 && in_range) || cmd_i.av_write;
  assign wa1 = cmd_i.av_write ? p_q : in_addr;
  assign wa2 = cmd_i.av_write ? q_q : in_addr;
  assign wd1 = cmd_i.av_write ? sum[SW:1] : {in_value_i, 1'b0};
  assign wd2 = wd1;

  // image stores
  always_ff @(posedge clk_i) begin
    if (we1) store1_mem[wa1] <= wd1;
    rd1_q <= store1_mem[ra1];
  end
  always_ff @(posedge clk_i) begin
    if (we2) store2_mem[wa2] <= wd2;
    rd2_q <= store2_mem[ra2];
  end

  // rank order stores
  always_ff @(posedge clk_i) begin
    if (cmd_i.rk_write) ord1_mem[rank1_q] <= i_cnt_q;
    ord1_rd_q <= ord1_mem[r_cnt_q];
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.rk_write) ord2_mem[rank2_q] <= i_cnt_q;
    ord2_rd_q <= ord2_mem[r_cnt_q];
  end

  // stable rank compare: smaller value, or equal value at lower index
  assign less1 = (rd1_q < vi1_q) || (rd1_q == vi1_q && cmp_j_q < i_cnt_q);
  assign less2 = (rd2_q < vi2_q) || (rd2_q == vi2_q && cmp_j_q < i_cnt_q);

  // sequencing counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_cnt_q  <= '0;
      j_cnt_q  <= '0;
      r_cnt_q  <= '0;
      cmp_en_q <= 1'b0;
      rank1_q  <= '0;
      rank2_q  <= '0;
    end else begin
      cmp_en_q <= cmd_i.rk_sweep;
      if (cmd_i.eq_init) begin
        i_cnt_q <= '0;
        r_cnt_q <= '0;
      end
      if (cmd_i.rk_cap) begin
        j_cnt_q <= '0;
        rank1_q <= '0;
        rank2_q <= '0;
      end else if (cmp_en_q) begin
        rank1_q <= rank1_q + AW'(less1);
        rank2_q <= rank2_q + AW'(less2);
      end
      if (cmd_i.rk_sweep) j_cnt_q <= j_cnt_q + AW'(1);
      if (cmd_i.rk_write) i_cnt_q <= i_cnt_q + AW'(1);
      if (cmd_i.av_write) r_cnt_q <= r_cnt_q + AW'(1);
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.rk_sweep) cmp_j_q <= j_cnt_q;
    if (cmd_i.rk_cap) begin
      vi1_q <= rd1_q;
      vi2_q <= rd2_q;
    end
    if (cmd_i.av_val) begin
      p_q <= ord1_rd_q;
      q_q <= ord2_rd_q;
    end
    if (cmd_i.accept) begin
      req_op_q    <= in_op_i;
      req_idx_q   <= in_index_i;
      req_range_q <= in_range;
    end
    if (cmd_i.res_read) begin
      res_kind_q  <= mheq_pkg::KIND_READ;
      res_index_q <= req_idx_q;
      if (!req_range_q)                          res_value_q <= '0;
      else if (req_op_q == mheq_pkg::OP_READ1)   res_value_q <= rd1_q;
      else                                       res_value_q <= rd2_q;
    end else if (cmd_i.res_done) begin
      res_kind_q  <= mheq_pkg::KIND_DONE;
      res_index_q <= '0;
      res_value_q <= '0;
    end
  end

  assign res_kind_o  = res_kind_q;
  assign res_index_o = res_index_q;
  assign res_value_o = res_value_q;

endmodule

FILE: rtl/mheq_ctrl.sv
// ---------------------------------------------------------------------------
// mheq_ctrl
// Sequencer for load, read and the rank/average passes of equalize.
// ---------------------------------------------------------------------------
`include "midway_histogram_equalization_unit_defines.svh"

module mheq_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [2:0]      in_op_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  mheq_pkg::sts_t  sts_i,
  output mheq_pkg::cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_EQ_START,
    ST_RK_FETCH,
    ST_RK_CAP,
    ST_RK_SWEEP,
    ST_RK_DRAIN,
    ST_RK_WRITE,
    ST_AV_ORD,
    ST_AV_VAL,
    ST_AV_WRITE,
    ST_RESULT
  } state_e;

  state_e state_q, state_d;
  logic   fire;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_RESULT);
  assign fire        = in_valid_i && in_ready_o;

  // command decode and next state
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        cmd_o.accept = fire;
        if (fire && (in_op_i == mheq_pkg::OP_READ1 || in_op_i == mheq_pkg::OP_READ2))
          state_d = ST_READ;
        else if (fire && in_op_i == mheq_pkg::OP_EQUAL)
          state_d = ST_EQ_START;
      end
      ST_READ: begin
        cmd_o.res_read = 1'b1;
        state_d = ST_RESULT;
      end
      ST_EQ_START: begin
        cmd_o.eq_init = 1'b1;
        if (sts_i.n_zero) begin
          cmd_o.res_done = 1'b1;
          state_d = ST_RESULT;
        end else begin
          state_d = ST_RK_FETCH;
        end
      end
      ST_RK_FETCH: begin
        cmd_o.rk_fetch = 1'b1;
        state_d = ST_RK_CAP;
      end
      ST_RK_CAP: begin
        cmd_o.rk_cap = 1'b1;
        state_d = ST_RK_SWEEP;
      end
      ST_RK_SWEEP: begin
        cmd_o.rk_sweep = 1'b1;
        if (sts_i.j_last) state_d = ST_RK_DRAIN;
      end
      ST_RK_DRAIN: state_d = ST_RK_WRITE;
      ST_RK_WRITE: begin
        cmd_o.rk_write = 1'b1;
        state_d = sts_i.i_last ? ST_AV_ORD : ST_RK_FETCH;
      end
      ST_AV_ORD: state_d = ST_AV_VAL;
      ST_AV_VAL: begin
        cmd_o.av_val = 1'b1;
        state_d = ST_AV_WRITE;
      end
      ST_AV_WRITE: begin
        cmd_o.av_write = 1'b1;
        if (sts_i.r_last) begin
          cmd_o.res_done = 1'b1;
          state_d = ST_RESULT;
        end else begin
          state_d = ST_AV_ORD;
        end
      end
      ST_RESULT: begin
        if (out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // checks
  `MHEQ_ASSERT(a_rd_port_excl, $onehot0({cmd_o.accept, cmd_o.rk_fetch, cmd_o.rk_sweep, cmd_o.av_val}))
  `MHEQ_ASSERT_IMP(a_write_after_drain, state_q == ST_RK_WRITE, $past(state_q) == ST_RK_DRAIN)
  `MHEQ_ASSERT_IMP(a_result_loaded, state_q == ST_RESULT && $past(state_q) != ST_RESULT,
                   $past(cmd_o.res_read) || $past(cmd_o.res_done))

endmodule
